### hw/rtl/gld_pkg.sv
// ----------------------------------------------------------------------------
// GIF LZW decoder package
// Shared status codes, register indexes and widths.
// ----------------------------------------------------------------------------
package gld_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [2:0] {
    ST_PIXEL   = 3'd0,
    ST_NEED    = 3'd1,
    ST_TAKEN   = 3'd2,
    ST_REFUSED = 3'd3,
    ST_DONE    = 3'd4,
    ST_ERROR   = 3'd5
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_CODE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_LIMIT   = 1'b1;

  typedef enum logic [1:0] {
    FIN_RUN   = 2'd0,
    FIN_DONE  = 2'd1,
    FIN_ERROR = 2'd2
  } finish_t;

  // Effective minimum code size: clamped to 2..8 and below the max width.
  function automatic logic [3:0] eff_min_size(input logic [3:0] s, input logic [3:0] max_bits);
    logic [3:0] r;
    r = s;
    if (r < 4'd2) r = 4'd2;
    if (r > 4'd8) r = 4'd8;
    if (r + 4'd1 > max_bits) r = max_bits - 4'd1;
    return r;
  endfunction

endpackage

### hw/rtl/gld_if.sv
// ----------------------------------------------------------------------------
// GIF LZW decoder channels
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
interface gld_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  modport source (output valid, kind, data_byte, input ready);
  modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface gld_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] pixel_index;
  modport source (output valid, status, pixel_index, input ready);
  modport sink   (input valid, status, pixel_index, output ready);
endinterface

### hw/rtl/gld_ram.sv
// ----------------------------------------------------------------------------
// GIF LZW decoder RAM
// Single-write, single-read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module gld_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/gif_lzw_decoder.sv
// ----------------------------------------------------------------------------
// GIF LZW decoder
// Streams joined GIF raster bytes in and pulls decoded pixel indexes out.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                 Word
// in_ch     in   kind, data_byte         push a data byte or pull a pixel
// out_ch    out  status, pixel_index     one answer per request word
// cfg       in   cfg_we, cfg_idx, cfg_data  register write
//
// A push is accepted, then answered. A pull that pops the expansion stack is
// accepted, checked, then reads the stack and answers. A pull that decodes a
// code handles each clear code, extracts the code, then for each character of
// the chain does a table read and then a stack push, then the stack read and
// the answer; the first code after a clear is answered directly. Reset is
// synchronous; the tables need no clearing. A result waits in the output
// register while the next request word is accepted; a new request is then
// held until the result is taken.
module gif_lzw_decoder #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int MAX_CODE_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  gld_in_if.sink                          in_ch,
  gld_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [gld_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [gld_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gld_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = AW + 1;
  localparam logic [3:0] MAXB = 4'(MAX_CODE_BITS);
  localparam logic [CW-1:0] ENTRIES = CW'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_CODE, S_WALK, S_WAIT, S_POP, S_FIN
  } state_t;

  state_t state;
  logic [3:0]   min_code_size;
  logic [31:0]  pixel_limit;
  logic [CW-1:0] stack_count;
  logic [23:0]  bit_buffer;
  logic [4:0]   bits_held;
  logic [3:0]   code_width;
  logic [CW-1:0] next_free_code;
  logic [AW-1:0] previous_code;
  logic [7:0]   last_first_char;
  logic         after_clear;
  logic [31:0]  pixels_delivered;
  finish_t      finish_state;
  logic [AW-1:0] code, cur;
  logic          pend_valid, pend_kind;
  logic [7:0]    pend_byte;
  logic          add_entry;

  // Memories.
  logic          tbl_we, stk_we;
  logic [AW-1:0] tbl_waddr, tbl_raddr, stk_waddr, stk_raddr;
  logic [AW-1:0] tbl_wpre, pre_rd;
  logic [7:0]    tbl_wsuf, suf_rd, stk_wdata, stk_rd;

  gld_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(AW)) u_prefix (
    .clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wpre),
    .raddr(tbl_raddr), .rdata(pre_rd));
  gld_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(8)) u_suffix (
    .clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wsuf),
    .raddr(tbl_raddr), .rdata(suf_rd));
  gld_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(8)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rd));

  logic [3:0]    eff_min;
  logic [CW-1:0] clr, eoi;
  logic [11:0]   raw_code;
  logic [CW-1:0] code_ext;

  assign eff_min  = eff_min_size(min_code_size, MAXB);
  assign clr      = CW'(1) << eff_min;
  assign eoi      = clr + CW'(1);
  assign raw_code = bit_buffer[11:0] & ((12'd1 << code_width) - 12'd1);
  assign code_ext = CW'(raw_code);

  assign in_ch.ready = !pend_valid && !rst;
  assign stk_raddr   = AW'(stack_count - CW'(1));
  assign tbl_raddr   = cur;

  logic [CW-1:0] cur_ext;
  assign cur_ext = CW'(cur);

  // Stack and table writes: first char for a code not yet in the table, then in the walk the suffix or final root.
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = AW'(stack_count);
    stk_wdata = 8'd0;
    tbl_we    = 1'b0;
    tbl_waddr = AW'(next_free_code);
    tbl_wpre  = previous_code;
    tbl_wsuf  = last_first_char;
    if (state == S_CODE && pend_valid && !out_ch.valid && bits_held >= 5'(code_width) &&
        code_ext != clr && code_ext != eoi && !after_clear &&
        next_free_code < ENTRIES && code_ext == next_free_code) begin
      stk_we    = 1'b1;
      stk_wdata = last_first_char;
    end else if (state == S_WALK && stack_count < ENTRIES) begin
      stk_we    = 1'b1;
      stk_wdata = (cur_ext >= clr) ? suf_rd : cur[7:0];
    end
    if (state == S_WALK && cur_ext < clr && stack_count < ENTRIES && add_entry) begin
      tbl_we   = 1'b1;
      tbl_wsuf = cur[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      min_code_size    <= 4'd8;
      pixel_limit      <= 32'hFFFF_FFFF;
      stack_count      <= '0;
      bit_buffer       <= '0;
      bits_held        <= '0;
      code_width       <= eff_min_size(4'd8, MAXB) + 4'd1;
      next_free_code   <= (CW'(1) << eff_min_size(4'd8, MAXB)) + CW'(2);
      previous_code    <= '0;
      last_first_char  <= '0;
      after_clear      <= 1'b0;
      pixels_delivered <= '0;
      finish_state     <= FIN_RUN;
      pend_valid       <= 1'b0;
      out_ch.valid     <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_idx == REG_MIN_CODE_SIZE) begin
          min_code_size    <= cfg_data[3:0];
          stack_count      <= '0;
          bit_buffer       <= '0;
          bits_held        <= '0;
          code_width       <= eff_min_size(cfg_data[3:0], MAXB) + 4'd1;
          next_free_code   <= (CW'(1) << eff_min_size(cfg_data[3:0], MAXB)) + CW'(2);
          previous_code    <= '0;
          last_first_char  <= '0;
          after_clear      <= 1'b0;
          pixels_delivered <= '0;
          finish_state     <= FIN_RUN;
        end else if (cfg_idx == REG_PIXEL_LIMIT) begin
          pixel_limit <= cfg_data;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pend_valid <= 1'b1;
        pend_kind  <= in_ch.kind;
        pend_byte  <= in_ch.data_byte;
        state      <= S_CODE;
      end
      unique case (state)
        S_IDLE: ;
        S_CODE: begin
          if (pend_valid && !out_ch.valid) begin
            if (!pend_kind) begin
              pend_valid <= 1'b0;
              state      <= S_IDLE;
              out_ch.valid <= 1'b1;
              out_ch.pixel_index <= '0;
              if (finish_state != FIN_RUN || bits_held > 5'd16) begin
                out_ch.status <= ST_REFUSED;
              end else begin
                bit_buffer <= bit_buffer | (24'(pend_byte) << bits_held);
                bits_held  <= bits_held + 5'd8;
                out_ch.status <= ST_TAKEN;
              end
            end else if (finish_state != FIN_RUN) begin
              pend_valid <= 1'b0; state <= S_IDLE; out_ch.valid <= 1'b1;
              out_ch.pixel_index <= '0;
              out_ch.status <= (finish_state == FIN_DONE) ? ST_DONE : ST_ERROR;
            end else if (pixels_delivered >= pixel_limit) begin
              pend_valid <= 1'b0; state <= S_IDLE; out_ch.valid <= 1'b1;
              out_ch.pixel_index <= '0;
              finish_state <= FIN_DONE; out_ch.status <= ST_DONE;
            end else if (stack_count != '0) begin
              state <= S_POP;
            end else if (bits_held < 5'(code_width)) begin
              pend_valid <= 1'b0; state <= S_IDLE; out_ch.valid <= 1'b1;
              out_ch.pixel_index <= '0;
              out_ch.status <= ST_NEED;
            end else begin
              bit_buffer <= bit_buffer >> code_width;
              bits_held  <= bits_held - 5'(code_width);
              if (code_ext == clr) begin
                code_width     <= eff_min + 4'd1;
                next_free_code <= clr + CW'(2);
                after_clear    <= 1'b1;
              end else if (code_ext == eoi) begin
                pend_valid <= 1'b0; state <= S_IDLE; out_ch.valid <= 1'b1;
                out_ch.pixel_index <= '0;
                finish_state <= FIN_DONE; out_ch.status <= ST_DONE;
              end else if (after_clear) begin
                pend_valid <= 1'b0; state <= S_IDLE; out_ch.valid <= 1'b1;
                if (code_ext > clr) begin
                  finish_state <= FIN_ERROR; out_ch.status <= ST_ERROR;
                  out_ch.pixel_index <= '0;
                end else begin
                  after_clear      <= 1'b0;
                  previous_code    <= AW'(code_ext);
                  last_first_char  <= raw_code[7:0];
                  pixels_delivered <= pixels_delivered + 32'd1;
                  out_ch.status    <= ST_PIXEL;
                  out_ch.pixel_index <= raw_code[7:0];
                end
              end else if (next_free_code >= ENTRIES || code_ext > next_free_code) begin
                pend_valid <= 1'b0; state <= S_IDLE; out_ch.valid <= 1'b1;
                out_ch.pixel_index <= '0;
                finish_state <= FIN_ERROR; out_ch.status <= ST_ERROR;
              end else begin
                code      <= AW'(code_ext);
                add_entry <= 1'b1;
                if (code_ext == next_free_code) begin
                  stack_count <= stack_count + CW'(1);
                  cur         <= previous_code;
                end else begin
                  cur <= AW'(code_ext);
                end
                state <= S_WAIT;
              end
            end
          end
        end
        S_WAIT: state <= S_WALK;  // table read of cur in flight
        S_WALK: begin
          if (stack_count >= ENTRIES) begin
            state <= S_FIN; finish_state <= FIN_ERROR;
            out_ch.status <= ST_ERROR; out_ch.pixel_index <= '0;
          end else begin
            stack_count <= stack_count + CW'(1);
            if (cur_ext >= clr) begin
              cur   <= pre_rd;
              state <= S_WAIT;
            end else begin
              last_first_char <= cur[7:0];
              previous_code   <= code;
              next_free_code  <= next_free_code + CW'(1);
              if ((next_free_code + CW'(1)) >= (CW'(1) << code_width) && code_width < MAXB)
                code_width <= code_width + 4'd1;
              add_entry <= 1'b0;
              state     <= S_POP;
            end
          end
        end
        S_POP: begin
          // Stack read address settles this cycle; data appears next.
          stack_count <= stack_count - CW'(1);
          pixels_delivered <= pixels_delivered + 32'd1;
          out_ch.status <= ST_PIXEL;
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_ch.status == ST_PIXEL) out_ch.pixel_index <= stk_rd;
          out_ch.valid <= 1'b1;
          pend_valid   <= 1'b0;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The stack read data is registered, so the pop's address (stack_count - 1
  // before decrement) is sampled in S_POP and the data is used in S_FIN.

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !in_ch.ready)
    else $error("request accepted while busy");
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= ENTRIES)
    else $error("stack count beyond table");
endmodule
